>>> hdl/modular_inverse_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular inverse block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

// Same-cycle implication.
`define MI_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("modular_inverse: same-cycle check failed");

// Next-cycle implication.
`define MI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("modular_inverse: next-cycle check failed");

`endif

>>> hdl/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Control bundles shared by the modular inverse datapath units.
// ----------------------------------------------------------------------------
package mi_pkg;

  // Divider step unit control
  typedef struct packed {
    logic clear;  // load dividend, zero partial remainder and product
    logic step;   // one quotient bit
  } div_ctl_t;

  // Normalizer control
  typedef struct packed {
    logic calc;   // fold coefficient magnitude below modulus
    logic emit;   // form result and strobe it
  } norm_ctl_t;

endpackage

>>> hdl/mi_div.sv
// ----------------------------------------------------------------------------
// mi_div
// Bit-serial restoring divider with fused quotient-times-coefficient product.
// ----------------------------------------------------------------------------
module mi_div #(
  parameter int unsigned W = 31
) (
  input  logic             clk_i,
  input  mi_pkg::div_ctl_t ctl_i,
  input  logic [W-1:0]     dividend_i,
  input  logic [W-1:0]     divisor_i,
  input  logic [W:0]       coef_i,
  output logic [W-1:0]     rem_o,
  output logic [W:0]       prod_o
);

  logic [W-1:0] sh_q, sh_d;    // dividend, shifted out MSB first
  logic [W-1:0] rem_q, rem_d;  // partial remainder
  logic [W:0]   acc_q, acc_d;  // q * coef, modulo 2^(W+1)
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;

  always_comb begin
    trial = {rem_q, sh_q[W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
    sh_d  = sh_q;
    rem_d = rem_q;
    acc_d = acc_q;
    if (ctl_i.clear) begin
      sh_d  = dividend_i;
      rem_d = '0;
      acc_d = '0;
    end else if (ctl_i.step) begin
      sh_d  = {sh_q[W-2:0], 1'b0};
      // trial stays below twice the divisor, so one subtract restores it
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      acc_d = {acc_q[W-1:0], 1'b0} + (ge ? coef_i : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign rem_o  = rem_q;
  assign prod_o = acc_q;

endmodule

>>> hdl/mi_norm.sv
// ----------------------------------------------------------------------------
// mi_norm
// Two-step reduction of the signed final coefficient into 0..modulus-1.
// ----------------------------------------------------------------------------
module mi_norm #(
  parameter int unsigned W = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mi_pkg::norm_ctl_t ctl_i,
  input  logic [W:0]        coef_i,
  input  logic [W-1:0]      mod_i,
  output logic [W-1:0]      inverse_o,
  output logic              done_o
);

  logic [W:0]   mag;
  logic [W:0]   fold;
  logic [W-1:0] r_q, r_d;
  logic         neg_q;
  logic [W-1:0] inv_q, inv_d;
  logic         done_q;

  always_comb begin
    mag  = coef_i[W] ? (~coef_i + 1'b1) : coef_i;
    fold = mag - {1'b0, mod_i};
    // |coef| never exceeds the modulus: one compare and subtract suffices
    r_d  = (mag >= {1'b0, mod_i}) ? fold[W-1:0] : mag[W-1:0];
    if (mod_i == '0) begin
      inv_d = '0;
    end else if (neg_q && (r_q != '0)) begin
      inv_d = mod_i - r_q;
    end else if (neg_q) begin
      inv_d = '0;
    end else begin
      inv_d = r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.calc) begin
      r_q   <= r_d;
      neg_q <= coef_i[W];
    end
    if (ctl_i.emit) begin
      inv_q <= inv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.emit;
    end
  end

  assign inverse_o = inv_q;
  assign done_o    = done_q;

endmodule

>>> hdl/modular_inverse.sv
// Flow: after the accepting edge the block runs R Euclid rounds, then the
//   normalize and output steps; R is at most about 46 for 31-bit operands.
// Throughput: one transaction at a time; busy drops with the done_o strobe, so
//   a new start is taken no earlier than the done_o strobe of the previous one.
//   Each round runs the bit-serial divider over all W quotient bits plus one update.
// Reset (rst_ni low, asynchronous) returns to idle, done_o low; no receiver stall.
// ----------------------------------------------------------------------------
// modular_inverse
// Extended Euclidean modular inverse: a bit-serial divider yields each
// quotient bit by bit while accumulating quotient times coefficient, then
// the remainder and coefficient pairs are updated and the final coefficient
// is normalized into 0..modulus-1.
// ----------------------------------------------------------------------------
`include "modular_inverse_assert.svh"

module modular_inverse #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] modulus_i,
  output logic [VALUE_WIDTH-1:0] inverse_o,
  output logic                   done_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] CntLast = CW'(W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,   // one quotient bit per cycle
    S_UPD,   // shift remainder / coefficient pairs
    S_NRM,   // fold coefficient magnitude
    S_OUT    // form and strobe result
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  // Euclid state: b is the running divisor, x/u the signed coefficient pair
  // kept as two's complement in W+1 bits (|x|, |u| never exceed the modulus,
  // so the wrap in the product cancels).
  logic [W-1:0]     b_q;
  logic [W-1:0]     m_q;
  logic [W:0]       x_q;
  logic [W:0]       u_q;

  logic             accept;
  mi_pkg::div_ctl_t  div_ctl;
  mi_pkg::norm_ctl_t norm_ctl;
  logic [W-1:0]     dividend;
  logic [W-1:0]     rem;
  logic [W:0]       prod;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // First round divides the value; later rounds divide the previous divisor.
  assign dividend = (state_q == S_IDLE) ? value_i : b_q;

  always_comb begin
    div_ctl.clear  = accept || (state_q == S_UPD);
    div_ctl.step   = (state_q == S_DIV);
    norm_ctl.calc  = (state_q == S_NRM);
    norm_ctl.emit  = (state_q == S_OUT);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (start) begin
          // zero modulus: skip the loop, the normalizer returns zero
          state_d = (modulus_i == '0) ? S_NRM : S_DIV;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        // new divisor is this round's remainder; zero ends the algorithm
        state_d = (rem == '0) ? S_NRM : S_DIV;
      end
      S_NRM: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Remainder and coefficient pairs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q <= modulus_i;
      m_q <= modulus_i;
      x_q <= (W+1)'(1);
      u_q <= '0;
    end else if (state_q == S_UPD) begin
      b_q <= rem;
      x_q <= u_q;
      u_q <= x_q - prod;
    end
  end

  mi_div #(
    .W (W)
  ) u_div (
    .clk_i      (clk_i),
    .ctl_i      (div_ctl),
    .dividend_i (dividend),
    .divisor_i  (b_q),
    .coef_i     (u_q),
    .rem_o      (rem),
    .prod_o     (prod)
  );

  mi_norm #(
    .W (W)
  ) u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (norm_ctl),
    .coef_i    (x_q),
    .mod_i     (m_q),
    .inverse_o (inverse_o),
    .done_o    (done_o)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `MI_ASSERT_NEXT(a_accept_busy, accept, busy)
  `MI_ASSERT_NEXT(a_out_done, state_q == S_OUT, done_o)
  `MI_ASSERT_NOW(a_done_range, done_o, (inverse_o < m_q) || (m_q == '0))
  `MI_ASSERT_NEXT(a_div_end, (state_q == S_DIV) && (cnt_q == CntLast), state_q == S_UPD)

endmodule

>>> tb/modular_inverse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_inverse_checker
// Watches the command and result ports of modular_inverse, works out the
// inverse for every accepted transaction and compares it with done_o results.
// ----------------------------------------------------------------------------
module modular_inverse_checker #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] modulus_i,
  input  logic [VALUE_WIDTH-1:0] inverse_i,
  input  logic                   done_i,
  output int                     pending_o,
  output int                     results_o,
  output int                     failures_o
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] modulus;
    logic [VALUE_WIDTH-1:0] inverse;
  } inverse_due_t;

  inverse_due_t inverses_due[$];
  inverse_due_t head;

  // Extended Euclid; coefficients stay within +-modulus, so 64 bits suffice.
  function automatic logic [VALUE_WIDTH-1:0] inverse_mod(
    input logic [VALUE_WIDTH-1:0] val,
    input logic [VALUE_WIDTH-1:0] modv
  );
    u64_t   rem_hi;
    u64_t   rem_lo;
    u64_t   quo;
    u64_t   rem_nx;
    u64_t   mag;
    longint coef_cur;
    longint coef_nxt;
    longint coef_tmp;
    if (modv == '0) return '0;
    rem_hi   = u64_t'(val);
    rem_lo   = u64_t'(modv);
    coef_cur = 1;
    coef_nxt = 0;
    while (rem_lo != 0) begin
      quo      = rem_hi / rem_lo;
      rem_nx   = rem_hi - quo * rem_lo;
      rem_hi   = rem_lo;
      rem_lo   = rem_nx;
      coef_tmp = coef_cur - coef_nxt * longint'(quo);
      coef_cur = coef_nxt;
      coef_nxt = coef_tmp;
    end
    if (coef_cur < 0) begin
      mag = u64_t'(-coef_cur) % u64_t'(modv);
      return (mag == 0) ? '0 : VALUE_WIDTH'(u64_t'(modv) - mag);
    end
    return VALUE_WIDTH'(u64_t'(coef_cur) % u64_t'(modv));
  endfunction

  // Counters start at zero (two-state ints) and are kept only here.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_i === 1'b1) begin
        if (inverses_due.size() == 0) begin
          failures_o++;
          $display("%0t: unexpected result: expected none, actual inverse %0d",
                   $time, inverse_i);
        end else begin
          head = inverses_due.pop_front();
          results_o++;
          if (inverse_i !== head.inverse) begin
            failures_o++;
            $display("%0t: inverse mismatch, value %0d modulus %0d:",
                     $time, head.value, head.modulus);
            $display("  expected %0d, actual %0d", head.inverse, inverse_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        head.value   = value_i;
        head.modulus = modulus_i;
        head.inverse = inverse_mod(value_i, modulus_i);
        inverses_due.push_back(head);
      end
      pending_o = inverses_due.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for modular_inverse: directed corner operands, then random
// operand pairs under several sender pacing modes; results are predicted
// and compared by modular_inverse_checker.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned W = 31;
  // Worst case: about 47 Euclid rounds plus the fixed overhead.
  localparam int DRAIN_CYCLES = 47 * (W + 1) + 16;
  // ~425 transactions at worst-case latency fit well within this limit.
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_PER_PHASE = 100;

  localparam logic [W-1:0] MAX_VAL = '1;
  // Consecutive Fibonacci numbers: the longest Euclid chain that fits in 31 bits.
  localparam logic [W-1:0] FIB_45  = W'(1134903170);
  localparam logic [W-1:0] FIB_46  = W'(1836311903);

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  logic         busy;
  logic [W-1:0] value_i;
  logic [W-1:0] modulus_i;
  logic [W-1:0] inverse_o;
  logic         done_o;

  int pending;
  int results;
  int failures;
  int cycle_count;
  int sent_count;
  int directed_count;
  int idle_pct;

  modular_inverse #(
    .VALUE_WIDTH(W)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .value_i  (value_i),
    .modulus_i(modulus_i),
    .inverse_o(inverse_o),
    .done_o   (done_o)
  );

  modular_inverse_checker #(
    .VALUE_WIDTH(W)
  ) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .value_i   (value_i),
    .modulus_i (modulus_i),
    .inverse_i (inverse_o),
    .done_i    (done_o),
    .pending_o (pending),
    .results_o (results),
    .failures_o(failures)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d inverses still outstanding",
             cycle_count, pending);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [W-1:0] rand_word();
    return W'($urandom);
  endfunction

  // Random word of random magnitude, so small and mid-size operands show up.
  function automatic logic [W-1:0] rand_scaled();
    return rand_word() >> $urandom_range(W - 1);
  endfunction

  // One command transaction. Inputs change on the falling edge only; while the
  // sender idles, start is low and the operand ports carry junk that the block
  // must ignore. Once start is raised it stays up until the accepting edge
  // (start high with busy low), then control returns at the next falling edge.
  task automatic send_operands(input logic [W-1:0] val, input logic [W-1:0] modv);
    while ($urandom_range(99) < idle_pct) begin
      start     <= 1'b0;
      value_i   <= rand_word();
      modulus_i <= rand_word();
      @(negedge clk_i);
    end
    start     <= 1'b1;
    value_i   <= val;
    modulus_i <= modv;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    @(negedge clk_i);
    sent_count++;
  endtask

  // Random operand pair; mostly full-range, with biased slices for small
  // moduli, shared factors, value above modulus and a prime modulus.
  task automatic send_random();
    logic [W-1:0] val;
    logic [W-1:0] modv;
    int unsigned  g;
    case ($urandom_range(9))
      6: begin
        val  = rand_word();
        modv = W'($urandom_range(255, 1));
      end
      7: begin
        // Not coprime: no flag, the block returns the reduced-pair inverse.
        g    = $urandom_range(1000, 2);
        val  = W'(g * $urandom_range(1 << 20, 0));
        modv = W'(g * $urandom_range(1 << 20, 1));
      end
      8: begin
        modv = rand_scaled();
        val  = rand_word() | modv;
      end
      9: begin
        val  = rand_word();
        modv = MAX_VAL;
      end
      default: begin
        val  = ($urandom_range(1)) ? rand_word() : rand_scaled();
        modv = ($urandom_range(1)) ? rand_word() : rand_scaled();
      end
    endcase
    if (modv == '0) modv = W'(1);
    send_operands(val, modv);
  endtask

  initial begin
    start          = 1'b0;
    value_i        = '0;
    modulus_i      = '0;
    rst_ni         = 1'b0;
    sent_count     = 0;
    directed_count = 0;
    idle_pct       = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners, back to back.
    send_operands('0, W'(1));               // modulus of one, value zero
    send_operands(W'(1), W'(1));
    send_operands(MAX_VAL, W'(1));
    send_operands('0, MAX_VAL);             // value zero
    send_operands(W'(1), MAX_VAL);
    send_operands(MAX_VAL, MAX_VAL);        // equal operands, not coprime
    send_operands(MAX_VAL - W'(1), MAX_VAL);
    send_operands(MAX_VAL, MAX_VAL - W'(1));    // value above modulus
    send_operands(W'(1), W'(2));
    send_operands(MAX_VAL, W'(2));
    send_operands(W'(2), W'(3));
    send_operands(W'(3), W'(7));
    send_operands(W'(100), W'(7));          // value reduced on the first round
    send_operands(W'(6), W'(9));            // shared factor 3
    send_operands(W'(4), W'(8));            // value divides modulus
    send_operands(FIB_45, FIB_46);          // longest quotient chain
    send_operands(FIB_46, FIB_45);
    send_operands(W'(1 << 30), W'(3));
    send_operands(W'(32'h2AAA_AAAA), W'(32'h5555_5555));
    send_operands(W'(32'h5555_5555), W'(32'h2AAA_AAAA));
    send_operands(W'(1 << 30), MAX_VAL);
    send_operands(MAX_VAL, W'(1 << 30));
    directed_count = sent_count;

    // Pacing phases: none, sender idle 83%, none again (the receiver cannot
    // stall, so its phase runs unthrottled), then a light 14% sender idle.
    idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random();
    idle_pct = 83;
    repeat (RANDOM_PER_PHASE) send_random();
    idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random();
    idle_pct = 14;
    repeat (RANDOM_PER_PHASE) send_random();
    start <= 1'b0;

    // Let every outstanding inverse arrive, then watch for stray strobes.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transactions (%0d directed corners, rest random operands)",
             sent_count, directed_count);
    $display("under four sender pacing phases; %0d inverses compared, %0d failures",
             results, failures);
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
